// ===== rtl/index_allocator_fifo_free_list_macros.svh =====
// ----------------------------------------------------------------------------
// index allocator assertion macros
// shared concurrent check forms, reset-qualified
// ----------------------------------------------------------------------------
`ifndef INDEX_ALLOCATOR_FIFO_FREE_LIST_MACROS_SVH
`define INDEX_ALLOCATOR_FIFO_FREE_LIST_MACROS_SVH

// same-cycle implication
`define IAFL_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IAFL_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iafl_pkg.sv =====
// ----------------------------------------------------------------------------
// iafl_pkg
// shared types and codes of the slot index allocator
// ----------------------------------------------------------------------------
package iafl_pkg;

    localparam int SLOT_W  = 10;
    localparam int GIVEN_W = 11;
    localparam int DATA_W  = 16;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [GIVEN_W-1:0]   given_slot;
    } result_t;

endpackage

// ===== rtl/index_allocator_fifo_free_list.sv =====
// ----------------------------------------------------------------------------
// index_allocator_fifo_free_list
// slot index allocator: reuse fifo of released indices over a bump counter,
// with an in-use bitmap guarding releases
// ----------------------------------------------------------------------------
//  channel  | dir | transfer carries
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | tuser: op (alloc/release), tdata: slot to release
//  m_*      | out | tdata: given_slot, status (one result per request)
//
// one request per cycle sustained while m_tready stays high; each request passes the
// decision stage, then sits in the result register until taken
// throughput is set by the single read port of the reuse fifo and of the
// bitmap, read at accept time and forwarded against the write of the
// request ahead
// after reset the bitmap is cleared one entry a cycle, with s_tready held low
// until the sweep has passed every entry
// m_tready low stalls the decision stage and then the input side
`include "index_allocator_fifo_free_list_macros.svh"

module index_allocator_fifo_free_list #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [iafl_pkg::DATA_W-1:0]    s_tdata,   // [9:0] slot
    input  logic                           s_tuser,   // [0] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iafl_pkg::DATA_W-1:0]    m_tdata    // [10:0] given_slot, [12:11] status
);
    import iafl_pkg::*;

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(POOL_SIZE - 1);
    localparam logic [CNT_W-1:0]   POOL_CNT   = CNT_W'(POOL_SIZE);
    localparam logic [GIVEN_W-1:0] FULL_GIVEN = GIVEN_W'(POOL_SIZE);
    localparam logic [31:0]        POOL_U     = 32'(POOL_SIZE);

    // storage
    logic [IDX_W-1:0] fifo_mem [POOL_SIZE];
    logic             map_mem  [POOL_SIZE];

    // bitmap clear after reset
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    // decision stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_op_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [IDX_W-1:0]  s1_idx;
    logic              s1_slot_ok;
    logic              s1_fire;

    // read data captured at accept, plus forwarding from the request ahead
    logic [IDX_W-1:0] fifo_rdata_reg;
    logic             map_rdata_reg;
    logic             fwd_fifo_hit_reg;
    logic [IDX_W-1:0] fwd_fifo_data_reg;
    logic             fwd_map_hit_reg;
    logic             fwd_map_val_reg;

    // allocator state
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] fresh_reg;
    logic [CNT_W-1:0] fresh_next;

    logic             accept;
    logic             out_ready;
    logic [SLOT_W-1:0] in_slot;
    logic [IDX_W-1:0] in_idx;

    logic             map_bit;
    logic [IDX_W-1:0] fifo_word;
    logic [IDX_W-1:0] alloc_idx;
    logic             pop;
    logic             push;
    logic             bump;
    logic             map_set;
    logic             map_clr;
    logic             do_pop;
    logic             do_push;
    logic             do_bump;
    result_t          result;

    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic             map_wdata;

    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_idx  = IDX_W'(in_slot);
    assign s1_idx  = IDX_W'(s1_slot_reg);
    assign s1_slot_ok = 32'(s1_slot_reg) < POOL_U;

    assign s_tready      = !clr_active_reg && (!s1_valid_reg || out_ready);
    assign accept        = s_tvalid && s_tready;
    assign s1_fire       = s1_valid_reg && out_ready;
    assign s1_valid_next = accept || (s1_valid_reg && !out_ready);

    // decide one request
    always_comb
    begin
        map_bit   = fwd_map_hit_reg ? fwd_map_val_reg : map_rdata_reg;
        fifo_word = fwd_fifo_hit_reg ? fwd_fifo_data_reg : fifo_rdata_reg;
        alloc_idx = fifo_word;
        pop       = 1'b0;
        push      = 1'b0;
        bump      = 1'b0;
        map_set   = 1'b0;
        map_clr   = 1'b0;
        result.status     = ST_OK;
        result.given_slot = GIVEN_W'(s1_slot_reg);
        if (s1_op_reg == OP_ALLOC)
        begin
            priority if (count_reg != '0)
            begin
                pop = 1'b1;
            end
            else if (fresh_reg != POOL_CNT)
            begin
                bump      = 1'b1;
                alloc_idx = IDX_W'(fresh_reg);
            end
            else
            begin
                result.status = ST_FULL;
            end
            map_set           = pop || bump;
            result.given_slot = map_set ? GIVEN_W'(alloc_idx) : FULL_GIVEN;
        end
        else
        begin
            if (s1_slot_ok && map_bit)
            begin
                map_clr = 1'b1;
                push    = count_reg != POOL_CNT;
            end
            else
            begin
                result.status = ST_NOT_USED;
            end
        end
    end

    assign do_pop  = s1_fire && pop;
    assign do_push = s1_fire && push;
    assign do_bump = s1_fire && bump;

    assign head_next  = do_pop ? ((head_reg == LAST_IDX) ? '0 : head_reg + 1'b1) : head_reg;
    assign tail_next  = do_push ? ((tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1) : tail_reg;
    assign count_next = do_push ? count_reg + 1'b1 : (do_pop ? count_reg - 1'b1 : count_reg);
    assign fresh_next = do_bump ? fresh_reg + 1'b1 : fresh_reg;

    // one bitmap write port, shared by the clear sweep and the decision stage
    assign map_we    = clr_active_reg || (s1_fire && (map_set || map_clr));
    assign map_waddr = clr_active_reg ? clr_addr_reg : (map_set ? alloc_idx : s1_idx);
    assign map_wdata = !clr_active_reg && map_set;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            fresh_reg      <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            s1_valid_reg <= s1_valid_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            fresh_reg    <= fresh_next;
        end
    end

    // request payload and forwarding against the write in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg         <= s_tuser;
            s1_slot_reg       <= in_slot;
            fwd_fifo_hit_reg  <= do_push && (tail_reg == head_next);
            fwd_fifo_data_reg <= s1_idx;
            fwd_map_hit_reg   <= map_we && (map_waddr == in_idx);
            fwd_map_val_reg   <= map_wdata;
        end
    end

    // reuse fifo
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[tail_reg] <= s1_idx;
        end
        if (accept)
        begin
            fifo_rdata_reg <= fifo_mem[head_next];
        end
    end

    // in-use bitmap
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (accept)
        begin
            map_rdata_reg <= map_mem[in_idx];
        end
    end

    iafl_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (out_ready),
        .in_result (result),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // checks
    `IAFL_CHECK(a_no_accept_in_clear, clk, rst_n, clr_active_reg, !s_tready, "transfer accepted during bitmap clear")
    `IAFL_CHECK(a_queue_within_fresh, clk, rst_n, 1'b1, count_reg <= fresh_reg, "reuse fifo holds more than ever allocated")
    `IAFL_CHECK_NEXT(a_pop_drops_count, clk, rst_n, do_pop, count_reg == $past(count_reg) - 1'b1, "fifo pop did not drop count")

endmodule

// ===== rtl/iafl_out_reg.sv =====
// ----------------------------------------------------------------------------
// iafl_out_reg
// result register on the master stream side
// ----------------------------------------------------------------------------
module iafl_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  iafl_pkg::result_t              in_result,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iafl_pkg::DATA_W-1:0]    m_tdata    // [10:0] given_slot, [12:11] status
);
    import iafl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    load;

    assign in_ready   = !valid_reg || m_tready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= in_result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = DATA_W'(result_reg);

endmodule

// ===== tb/index_allocator_fifo_free_list_test.sv =====
// ----------------------------------------------------------------------------
// index_allocator_fifo_free_list_test
// self-checking bench for the slot index allocator: requests go in on the
// s_* stream, a local model of the reuse fifo, bump counter and in-use map
// predicts each grant, and every m_* transfer is checked in order against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module index_allocator_fifo_free_list_test;

    import iafl_pkg::*;

    localparam int POOL_SIZE      = 1024;
    localparam int HOLDOFF_CYCLES = 300;
    // no transfer on either side for this long means the block is hung;
    // covers the bitmap clear after reset plus the long
    // receiver hold-off, several times over
    localparam int STALL_LIMIT    = 8000;
    localparam int TAIL_CYCLES    = 20;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [9:0] slot, rest zero
    logic                s_tuser;   // [0] op
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;   // [10:0] given_slot, [12:11] status

    // model of the allocator, advanced once per accepted request
    logic [SLOT_W-1:0]   reuse_q[$];            // released indices, oldest first
    int unsigned         fresh_next;            // next never-used index
    bit                  slot_busy[POOL_SIZE];  // in-use map
    logic [SLOT_W-1:0]   held_slots[$];         // indices granted and not released
    logic [SLOT_W-1:0]   last_released;

    result_t             pending_grants[$];     // predicted results, oldest first
    int                  error_count;

    // idle rates in percent of cycles, and hold-off handshake between processes
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  holdoff_requests;
    int                  holdoff_served;

    index_allocator_fifo_free_list #(
        .POOL_SIZE (POOL_SIZE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // work out the grant for one accepted request and queue it
    function automatic void predict_grant(input logic op, input logic [SLOT_W-1:0] slot);
        result_t grant;
        int      where[$];
        if (op == OP_ALLOC)
        begin
            if (reuse_q.size() != 0)
            begin
                grant.given_slot = {1'b0, reuse_q.pop_front()};
                grant.status     = ST_OK;
            end
            else if (fresh_next < POOL_SIZE)
            begin
                grant.given_slot = GIVEN_W'(fresh_next);
                grant.status     = ST_OK;
                fresh_next++;
            end
            else
            begin
                // pool exhausted: nothing changes
                grant.given_slot = GIVEN_W'(POOL_SIZE);
                grant.status     = ST_FULL;
            end
            if (grant.status == ST_OK)
            begin
                slot_busy[grant.given_slot[SLOT_W-1:0]] = 1'b1;
                held_slots.push_back(grant.given_slot[SLOT_W-1:0]);
            end
        end
        else
        begin
            grant.given_slot = {1'b0, slot};
            if (slot_busy[slot])
            begin
                slot_busy[slot] = 1'b0;
                if (reuse_q.size() < POOL_SIZE)
                    reuse_q.push_back(slot);
                where = held_slots.find_first_index(x) with (x == slot);
                if (where.size() != 0)
                    held_slots.delete(where[0]);
                last_released = slot;
                grant.status  = ST_OK;
            end
            else
            begin
                // double release or never granted: ignored and flagged
                grant.status = ST_NOT_USED;
            end
        end
        pending_grants.push_back(grant);
    endfunction

    // offer one request, with random idle cycles ahead of it, until accepted
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(DATA_W-SLOT_W){1'b0}}, slot};
        do
            @(posedge clk);
        while (!s_tready);
        predict_grant(op, slot);
    endtask

    // sender pauses until every predicted result has come back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // corners right after reset: releases of free indices, double release,
    // fifo reuse order ahead of the bump counter, alternating slot bits
    task automatic test_directed_corners();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_request(OP_RELEASE, 10'd0);
        send_request(OP_RELEASE, 10'h3FF);
        send_request(OP_ALLOC, 10'h3FF);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_RELEASE, 10'd1);
        send_request(OP_RELEASE, 10'd1);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_RELEASE, 10'd0);
        send_request(OP_RELEASE, 10'd2);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_RELEASE, 10'h2AA);
        send_request(OP_RELEASE, 10'h155);
        send_request(OP_RELEASE, 10'd3);
        wait_drained();
    endtask

    // fill the whole pool behind a long receiver hold-off, run into full, reuse three released indices,
    // then hand a batch back in random order into the reuse fifo and end on a double release
    task automatic test_exhaust_and_drain_pool();
        int pos;
        send_idle_pct = 0;
        recv_idle_pct = 20;
        holdoff_requests++;
        while (held_slots.size() < POOL_SIZE)
            send_request(OP_ALLOC, 10'($urandom));
        repeat (4) send_request(OP_ALLOC, 10'($urandom));
        repeat (3)
        begin
            pos = $urandom_range(held_slots.size() - 1);
            send_request(OP_RELEASE, held_slots[pos]);
        end
        repeat (4) send_request(OP_ALLOC, 10'd0);
        repeat (40)
        begin
            if (held_slots.size() != 0)
            begin
                pos = $urandom_range(held_slots.size() - 1);
                send_request(OP_RELEASE, held_slots[pos]);
            end
        end
        send_request(OP_RELEASE, last_released);
        wait_drained();
    endtask

    // mostly well-formed traffic: allocations and releases of held indices,
    // with some releases of random or just-released indices mixed in
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int alloc_pct, input int count);
        int pick;
        int pos;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < alloc_pct)
                send_request(OP_ALLOC, 10'($urandom));
            else if (pick < 90 && held_slots.size() != 0)
            begin
                pos = $urandom_range(held_slots.size() - 1);
                send_request(OP_RELEASE, held_slots[pos]);
            end
            else if (pick[0])
                send_request(OP_RELEASE, 10'($urandom));
            else
                send_request(OP_RELEASE, last_released);
        end
        wait_drained();
    endtask

    // result side: random stalls, plus a long hold-off counted here
    initial
    begin : result_sink
        int hold_left;
        hold_left      = 0;
        holdoff_served = 0;
        m_tready       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_served != holdoff_requests)
            begin
                hold_left      = HOLDOFF_CYCLES;
                holdoff_served = holdoff_requests;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[GIVEN_W+1:0]);
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got given_slot %0d status %0d",
                         $time, got.given_slot, got.status);
                error_count++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.given_slot !== want.given_slot)
                begin
                    $display("%0t: given_slot mismatch, expected %0d, got %0d",
                             $time, want.given_slot, got.given_slot);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // hang detection: too long without a transfer on either side
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("index_allocator_fifo_free_list_test: done, errors");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tuser          = OP_ALLOC;
        s_tdata          = '0;
        fresh_next       = 0;
        last_released    = '0;
        error_count      = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        holdoff_requests = 0;
        foreach (slot_busy[i])
            slot_busy[i] = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_exhaust_and_drain_pool();
        test_random_traffic(15, 54, 60, 40);
        test_random_traffic(54, 15, 35, 40);
        test_random_traffic(0, 0, 50, 40);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_grants.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected given_slot %0d status %0d",
                     $time, pending_grants.size(), pending_grants[0].given_slot,
                     pending_grants[0].status);
            error_count++;
        end
        if (error_count == 0)
            $display("index_allocator_fifo_free_list_test: done, clean");
        else
            $display("index_allocator_fifo_free_list_test: done, errors");
        $finish;
    end

endmodule
